// File: rtl/lab_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the look-at basis unit and its vector normalizer.
// No dependencies.
package lab_pkg;

  localparam int HI_FRAC = 30;   // fraction bits of the internal look and right axes
  localparam int HI_W    = 32;   // signed Q1.30 width of those axes
  localparam int NORM_W  = 31;   // the largest magnitude is normalized into [2^30, 2^31)
  localparam int SQ_W    = 64;   // sum of three squared normalized magnitudes
  localparam int ROOT_W  = 32;   // integer square root of that sum
  localparam int QUO_W   = 32;   // floor(a * 2^31 / root), at most 2^31
  localparam int REM_W   = 33;   // partial remainder of the divider
  localparam int ISQ_STEPS = 32; // one root bit per stage
  localparam int DIV_STEPS = 32; // one quotient bit per stage

endpackage

// File: rtl/lab_norm.sv
`timescale 1ns / 1ps
// Pipelined normalizer of a three-component signed vector: abs, shift search, squares,
// bit-serial square root and bit-serial division, rounding. Depends on lab_pkg.
module lab_norm
  import lab_pkg::*;
#(
  parameter int IN_W  = 33,
  parameter int OUT_F = 14,
  parameter int TAG_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  logic [2:0][IN_W-1:0]  vec_i,
  input  logic [TAG_W-1:0]      tag_i,
  output logic                  valid_o,
  output logic [2:0][OUT_F+1:0] lo_o,
  output logic [2:0][HI_W-1:0]  hi_o,
  output logic [TAG_W-1:0]      tag_o
);

  localparam int NG    = (IN_W + 7) / 8;
  localparam int PW    = $clog2(NG * 8);
  localparam int EXT_W = IN_W + NORM_W;
  localparam int OW    = OUT_F + 2;
  localparam logic [QUO_W:0] ONE_LO = (QUO_W + 1)'(1) << OUT_F;
  localparam logic [QUO_W:0] ONE_HI = (QUO_W + 1)'(1) << HI_FRAC;

  typedef struct packed {
    logic [2:0][NORM_W-1:0] mag;
    logic [2:0]             sgn;
    logic                   zero;
    logic [TAG_W-1:0]       tag;
  } iq_side_t;

  typedef struct packed {
    logic [2:0]        sgn;
    logic              zero;
    logic [TAG_W-1:0]  tag;
    logic [ROOT_W-1:0] root;
  } dv_side_t;

  // Stage A: magnitudes and signs.
  logic                 va_q;
  logic [2:0][IN_W-1:0] a_a_q;
  logic [2:0]           sg_a_q;
  logic [TAG_W-1:0]     tg_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 3; c++) begin
        sg_a_q[c] <= vec_i[c][IN_W-1];
        a_a_q[c]  <= vec_i[c][IN_W-1] ? (~vec_i[c] + IN_W'(1)) : vec_i[c];
      end
      tg_a_q <= tag_i;
    end
  end

  // Stage B: per-byte leading-one search on the OR of the magnitudes. The OR has
  // its top bit where the largest magnitude has it.
  logic [NG*8-1:0]      mor;
  logic [NG-1:0]        gnz_d;
  logic [NG-1:0][2:0]   gpos_d;
  logic                 vb_q;
  logic [2:0][IN_W-1:0] a_b_q;
  logic [2:0]           sg_b_q;
  logic                 zr_b_q;
  logic [TAG_W-1:0]     tg_b_q;
  logic [NG-1:0]        gnz_q;
  logic [NG-1:0][2:0]   gpos_q;

  assign mor = (NG * 8)'(a_a_q[0] | a_a_q[1] | a_a_q[2]);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gnz_d[g]  = |mor[g*8 +: 8];
      gpos_d[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (mor[g*8+b]) begin
          gpos_d[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_b_q  <= a_a_q;
      sg_b_q <= sg_a_q;
      zr_b_q <= ~|mor;
      tg_b_q <= tg_a_q;
      gnz_q  <= gnz_d;
      gpos_q <= gpos_d;
    end
  end

  // Stage C: pick the highest nonzero byte.
  logic [PW-1:0]        p_d;
  logic                 vc_q;
  logic [2:0][IN_W-1:0] a_c_q;
  logic [2:0]           sg_c_q;
  logic                 zr_c_q;
  logic [TAG_W-1:0]     tg_c_q;
  logic [PW-1:0]        p_c_q;

  always_comb begin
    p_d = '0;
    for (int g = 0; g < NG; g++) begin
      if (gnz_q[g]) begin
        p_d = PW'(g * 8 + int'(gpos_q[g]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv_i) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_c_q  <= a_b_q;
      sg_c_q <= sg_b_q;
      zr_c_q <= zr_b_q;
      tg_c_q <= tg_b_q;
      p_c_q  <= p_d;
    end
  end

  // Stage D: one shift brings the top bit to position 30; bits below fall off.
  logic [PW:0]             shamt;
  logic [2:0][EXT_W-1:0]   ext;
  logic                    vd_q;
  logic [2:0][NORM_W-1:0]  n_d_q;
  logic [2:0]              sg_d_q;
  logic                    zr_d_q;
  logic [TAG_W-1:0]        tg_d_q;

  assign shamt = {1'b0, p_c_q} + (PW + 1)'(1);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ext[c] = {a_c_q[c], {NORM_W{1'b0}}} >> shamt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (adv_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 3; c++) begin
        n_d_q[c] <= ext[c][NORM_W-1:0];
      end
      sg_d_q <= sg_c_q;
      zr_d_q <= zr_c_q;
      tg_d_q <= tg_c_q;
    end
  end

  // Stage E: squares.
  logic                     ve_q;
  logic [2:0][2*NORM_W-1:0] sq_e_q;
  iq_side_t                 sd_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (adv_i) begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < 3; c++) begin
        sq_e_q[c] <= n_d_q[c] * n_d_q[c];
      end
      sd_e_q.mag  <= n_d_q;
      sd_e_q.sgn  <= sg_d_q;
      sd_e_q.zero <= zr_d_q;
      sd_e_q.tag  <= tg_d_q;
    end
  end

  // Stage F: sum of squares.
  logic            vf_q;
  logic [SQ_W-1:0] s_f_q;
  iq_side_t        sd_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (adv_i) begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s_f_q  <= SQ_W'(sq_e_q[0]) + SQ_W'(sq_e_q[1]) + SQ_W'(sq_e_q[2]);
      sd_f_q <= sd_e_q;
    end
  end

  // Square root, one result bit per stage, trial bit walking down from 2^62.
  logic            iq_v_q [ISQ_STEPS];
  logic [SQ_W-1:0] iq_n_q [ISQ_STEPS];
  logic [SQ_W-1:0] iq_r_q [ISQ_STEPS];
  iq_side_t        iq_s_q [ISQ_STEPS];

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (ISQ_STEPS - 1 - k));
    logic            v_in;
    logic [SQ_W-1:0] n_in;
    logic [SQ_W-1:0] r_in;
    iq_side_t        s_in;
    logic [SQ_W-1:0] trial;

    if (k == 0) begin : g_first
      assign v_in = vf_q;
      assign n_in = s_f_q;
      assign r_in = '0;
      assign s_in = sd_f_q;
    end else begin : g_next
      assign v_in = iq_v_q[k-1];
      assign n_in = iq_n_q[k-1];
      assign r_in = iq_r_q[k-1];
      assign s_in = iq_s_q[k-1];
    end

    assign trial = r_in + BITV;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        iq_v_q[k] <= 1'b0;
      end else if (adv_i) begin
        iq_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        if (n_in >= trial) begin
          iq_n_q[k] <= n_in - trial;
          iq_r_q[k] <= (r_in >> 1) + BITV;
        end else begin
          iq_n_q[k] <= n_in;
          iq_r_q[k] <= r_in >> 1;
        end
        iq_s_q[k] <= s_in;
      end
    end
  end

  // Restoring division of a * 2^31 by the root, one quotient bit per stage.
  logic                   dv_v_q   [DIV_STEPS];
  logic [2:0][REM_W-1:0]  dv_rem_q [DIV_STEPS];
  logic [2:0][QUO_W-1:0]  dv_quo_q [DIV_STEPS];
  dv_side_t               dv_s_q   [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic                  v_in;
    logic [2:0][REM_W-1:0] rem_in;
    logic [2:0][QUO_W-1:0] quo_in;
    dv_side_t              s_in;
    logic [2:0]            ge;
    logic [2:0][REM_W-1:0] rem_nx;

    if (j == 0) begin : g_first
      assign v_in = iq_v_q[ISQ_STEPS-1];
      for (genvar c = 0; c < 3; c++) begin : g_init
        assign rem_in[c] = REM_W'(iq_s_q[ISQ_STEPS-1].mag[c]);
      end
      assign quo_in     = '0;
      assign s_in.sgn   = iq_s_q[ISQ_STEPS-1].sgn;
      assign s_in.zero  = iq_s_q[ISQ_STEPS-1].zero;
      assign s_in.tag   = iq_s_q[ISQ_STEPS-1].tag;
      assign s_in.root  = iq_r_q[ISQ_STEPS-1][ROOT_W-1:0];
    end else begin : g_next
      assign v_in   = dv_v_q[j-1];
      assign rem_in = dv_rem_q[j-1];
      assign quo_in = dv_quo_q[j-1];
      assign s_in   = dv_s_q[j-1];
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        ge[c]     = rem_in[c] >= REM_W'(s_in.root);
        rem_nx[c] = ge[c] ? (rem_in[c] - REM_W'(s_in.root)) : rem_in[c];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j] <= 1'b0;
      end else if (adv_i) begin
        dv_v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        for (int c = 0; c < 3; c++) begin
          // The remainder stays below the root, so doubling it fits.
          dv_rem_q[j][c] <= {rem_nx[c][REM_W-2:0], 1'b0};
          dv_quo_q[j][c] <= {quo_in[c][QUO_W-2:0], ge[c]};
        end
        dv_s_q[j] <= s_in;
      end
    end
  end

  // Rounding: floor((t / 2^k + 1) / 2) equals the round-half-up quotient.
  logic [2:0][OW-1:0]   lo_d;
  logic [2:0][HI_W-1:0] hi_d;
  logic                 vo_q;
  logic [2:0][OW-1:0]   lo_q;
  logic [2:0][HI_W-1:0] hi_q;
  logic [TAG_W-1:0]     tg_o_q;

  always_comb begin
    logic [QUO_W-1:0] tl;
    logic [QUO_W:0]   rl;
    logic [QUO_W:0]   rh;
    for (int c = 0; c < 3; c++) begin
      tl = dv_quo_q[DIV_STEPS-1][c] >> (HI_FRAC - OUT_F);
      rl = ({1'b0, tl} + (QUO_W + 1)'(1)) >> 1;
      rh = ({1'b0, dv_quo_q[DIV_STEPS-1][c]} + (QUO_W + 1)'(1)) >> 1;
      if (rl > ONE_LO) begin
        rl = ONE_LO;
      end
      if (rh > ONE_HI) begin
        rh = ONE_HI;
      end
      if (dv_s_q[DIV_STEPS-1].zero) begin
        rl = '0;
        rh = '0;
      end
      lo_d[c] = dv_s_q[DIV_STEPS-1].sgn[c] ? (~rl[OW-1:0] + OW'(1)) : rl[OW-1:0];
      hi_d[c] = dv_s_q[DIV_STEPS-1].sgn[c] ? (~rh[HI_W-1:0] + HI_W'(1)) : rh[HI_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv_i) begin
      vo_q <= dv_v_q[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      tg_o_q <= dv_s_q[DIV_STEPS-1].tag;
    end
  end

  assign valid_o = vo_q;
  assign lo_o    = lo_q;
  assign hi_o    = hi_q;
  assign tag_o   = tg_o_q;

endmodule

// File: rtl/look_at_basis_unit.sv
`timescale 1ns / 1ps
// Look-at basis unit: top level with point difference, cross product and output register.
// Depends on lab_pkg and lab_norm.
//
// Usage: each word on the slave stream holds a source and a destination point
// (six signed Q16.16 coordinates). Each word on the master stream holds the right,
// up and look unit axes as signed Q1.14 values, and tuser flags coinciding points,
// for which the identity axes are returned.
// The block is one pipeline of 146 register stages: difference (1), look and right
// normalizers in parallel (71), up cross product (2), up normalizer (71), output (1).
// Each normalizer spends 32 stages on the square root and 32 on the division, one
// bit per stage. When the receiver does not stall, a word is accepted every cycle,
// so throughput is one word per clock.
// When the receiver holds tready low with a word waiting, the whole pipeline holds
// and s_axis_tready_o goes low; nothing is lost or repeated. Reset clears every
// valid bit, so the pipeline comes up empty and ready.
module look_at_basis_unit
  import lab_pkg::*;
#(
  parameter int COORD_WIDTH   = 32,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // source_x, source_y, source_z, target_x, target_y, target_z from bit 0 up
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // right_x, right_y, right_z, up_x, up_y, up_z, look_x, look_y, look_z from bit 0 up
  output logic [((9*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata_o,
  // points_equal
  output logic                                   m_axis_tuser_o
);

  localparam int DW     = COORD_WIDTH + 1;
  localparam int OW     = OUT_FRAC_BITS + 2;
  localparam int OUT_DW = ((9 * OW + 7) / 8) * 8;
  localparam int PROD_W = 2 * HI_W;
  localparam int UV_W   = 63;
  localparam int TAG_W  = 6 * OW + 1;
  localparam logic [OW-1:0] ONE = OW'(1) << OUT_FRAC_BITS;

  logic adv;

  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Difference stage.
  logic [2:0][DW-1:0]  d_d;
  logic                eq_d;
  logic                v1_q;
  logic [2:0][DW-1:0]  d_q;
  logic                eq_q;

  always_comb begin
    logic [COORD_WIDTH-1:0] src;
    logic [COORD_WIDTH-1:0] tgt;
    eq_d = 1'b1;
    for (int c = 0; c < 3; c++) begin
      src    = s_axis_tdata_i[c*COORD_WIDTH +: COORD_WIDTH];
      tgt    = s_axis_tdata_i[(3+c)*COORD_WIDTH +: COORD_WIDTH];
      d_d[c] = {tgt[COORD_WIDTH-1], tgt} - {src[COORD_WIDTH-1], src};
      eq_d   = eq_d && (src == tgt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q  <= d_d;
      eq_q <= eq_d;
    end
  end

  // World up crossed with the difference.
  logic [2:0][DW-1:0] rv;

  assign rv[0] = d_q[2];
  assign rv[1] = '0;
  assign rv[2] = ~d_q[0] + DW'(1);

  logic                 nd_valid;
  logic                 nr_valid;
  logic [2:0][OW-1:0]   lo_look;
  logic [2:0][OW-1:0]   lo_right;
  logic [2:0][HI_W-1:0] hi_look;
  logic [2:0][HI_W-1:0] hi_right;
  logic                 nd_eq;

  lab_norm #(
    .IN_W  (DW),
    .OUT_F (OUT_FRAC_BITS),
    .TAG_W (1)
  ) u_norm_look (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v1_q),
    .vec_i   (d_q),
    .tag_i   (eq_q),
    .valid_o (nd_valid),
    .lo_o    (lo_look),
    .hi_o    (hi_look),
    .tag_o   (nd_eq)
  );

  lab_norm #(
    .IN_W  (DW),
    .OUT_F (OUT_FRAC_BITS),
    .TAG_W (1)
  ) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v1_q),
    .vec_i   (rv),
    .tag_i   (eq_q),
    .valid_o (nr_valid),
    .lo_o    (lo_right),
    .hi_o    (hi_right),
    .tag_o   ()
  );

  // Up vector: look crossed with right, products first, then the difference.
  logic                     vp_q;
  logic signed [PROD_W-1:0] p_q [4];
  logic [TAG_W-1:0]         tg_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (adv) begin
      vp_q <= nd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= $signed(hi_look[1]) * $signed(hi_right[2]);
      p_q[1] <= $signed(hi_look[2]) * $signed(hi_right[0]);
      p_q[2] <= $signed(hi_look[0]) * $signed(hi_right[2]);
      p_q[3] <= $signed(hi_look[1]) * $signed(hi_right[0]);
      tg_p_q <= {nd_eq, lo_right, lo_look};
    end
  end

  logic                 vu_q;
  logic [2:0][UV_W-1:0] uv_q;
  logic [TAG_W-1:0]     tg_u_q;
  logic [PROD_W-1:0]    uv1_full;
  logic [PROD_W-1:0]    uv2_full;

  assign uv1_full = p_q[1] - p_q[2];
  assign uv2_full = -p_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vu_q <= 1'b0;
    end else if (adv) begin
      vu_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      uv_q[0] <= UV_W'(p_q[0]);
      uv_q[1] <= uv1_full[UV_W-1:0];
      uv_q[2] <= uv2_full[UV_W-1:0];
      tg_u_q  <= tg_p_q;
    end
  end

  logic                 nu_valid;
  logic [2:0][OW-1:0]   lo_up;
  logic [TAG_W-1:0]     nu_tag;

  lab_norm #(
    .IN_W  (UV_W),
    .OUT_F (OUT_FRAC_BITS),
    .TAG_W (TAG_W)
  ) u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (vu_q),
    .vec_i   (uv_q),
    .tag_i   (tg_u_q),
    .valid_o (nu_valid),
    .lo_o    (lo_up),
    .hi_o    (),
    .tag_o   (nu_tag)
  );

  // Output register; coinciding points take the identity axes.
  logic [2:0][OW-1:0] f_look;
  logic [2:0][OW-1:0] f_right;
  logic               f_eq;
  logic [2:0][OW-1:0] o_right;
  logic [2:0][OW-1:0] o_up;
  logic [2:0][OW-1:0] o_look;
  logic               out_valid_q;
  logic [OUT_DW-1:0]  out_data_q;
  logic               out_user_q;

  assign f_look  = nu_tag[3*OW-1:0];
  assign f_right = nu_tag[6*OW-1:3*OW];
  assign f_eq    = nu_tag[6*OW];

  always_comb begin
    if (f_eq) begin
      o_right = {OW'(0), OW'(0), ONE};
      o_up    = {OW'(0), ONE, OW'(0)};
      o_look  = {ONE, OW'(0), OW'(0)};
    end else begin
      o_right = f_right;
      o_up    = lo_up;
      o_look  = f_look;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= nu_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= OUT_DW'({o_look, o_up, o_right});
      out_user_q <= f_eq;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // The two first normalizers must stay in lockstep.
  a_norm_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    nd_valid == nr_valid)
    else $error("look and right normalizers out of step");

  // A held output freezes the front of the pipeline.
  a_front_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(v1_q) && $stable(vu_q))
    else $error("pipeline moved while the output was stalled");

  // The x and z components of the look axis stay within plus or minus one.
  a_look_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ($signed(out_data_q[6*OW +: OW]) <= $signed(ONE)) &&
      ($signed(out_data_q[6*OW +: OW]) >= -$signed(ONE)) &&
      ($signed(out_data_q[8*OW +: OW]) <= $signed(ONE)) &&
      ($signed(out_data_q[8*OW +: OW]) >= -$signed(ONE)))
    else $error("look axis out of range");

endmodule

// File: dv/tb_look_at_basis_unit.sv
`timescale 1ns / 1ps
// Testbench for look_at_basis_unit: random and directed point pairs, with a built-in predictor
// of the right, up and look axes. Depends on lab_pkg and the RTL of the block.
module tb_look_at_basis_unit
  import lab_pkg::*;
;

  localparam int CW       = 32;
  localparam int OF       = 14;
  localparam int OW       = OF + 2;
  localparam int IN_W     = ((6 * CW + 7) / 8) * 8;
  localparam int OUT_W    = ((9 * OW + 7) / 8) * 8;
  localparam int LATENCY  = 146;
  localparam int LIMIT    = 400000;
  localparam int N_RANDOM = 830;

  typedef longint vec3_t [3];

  typedef struct {
    logic [OUT_W-1:0] axes;
    logic             equal;
  } basis_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;

  look_at_basis_unit #(
    .COORD_WIDTH  (CW),
    .OUT_FRAC_BITS(OF)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  logic [IN_W-1:0] pair_queue [$];
  basis_t          basis_queue [$];
  int              mismatches;
  int              words_in;
  int              cycles;
  logic            in_fire;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scale so the largest magnitude sits in [2^30, 2^31), then divide by the rounded-down norm.
  function automatic void unit_axis(input vec3_t c, input int frac, output vec3_t o);
    longint unsigned a [3];
    longint unsigned m, s, r, q, one;
    m = 0;
    s = 0;
    one = 64'd1 << frac;
    for (int i = 0; i < 3; i++) begin
      a[i] = (c[i] < 0) ? longint'(-c[i]) : c[i];
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    while (m >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
      m = m >> 1;
    end
    while (m < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
      m = m << 1;
    end
    for (int i = 0; i < 3; i++) s = s + a[i] * a[i];
    r = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << (frac + 1)) + r) / (2 * r);
      if (q > one) q = one;
      o[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic basis_t look_at_basis(input logic [IN_W-1:0] w);
    basis_t  b;
    vec3_t   d, rv, lo, ro, uo, lh, rh, uv;
    longint  src, dst;
    logic [OW-1:0] f [9];
    for (int i = 0; i < 3; i++) begin
      src  = longint'($signed(w[CW*i +: CW]));
      dst  = longint'($signed(w[CW*(i+3) +: CW]));
      d[i] = dst - src;
    end
    b.axes = '0;
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
      b.axes[0*OW +: OW] = OW'(1 << OF);
      b.axes[4*OW +: OW] = OW'(1 << OF);
      b.axes[8*OW +: OW] = OW'(1 << OF);
      b.equal = 1'b1;
      return b;
    end
    rv[0] = d[2];
    rv[1] = 0;
    rv[2] = -d[0];
    unit_axis(d, OF, lo);
    unit_axis(rv, OF, ro);
    unit_axis(d, HI_FRAC, lh);
    unit_axis(rv, HI_FRAC, rh);
    uv[0] = lh[1] * rh[2];
    uv[1] = lh[2] * rh[0] - lh[0] * rh[2];
    uv[2] = -(lh[1] * rh[0]);
    unit_axis(uv, OF, uo);
    for (int i = 0; i < 3; i++) begin
      f[i]     = ro[i][OW-1:0];
      f[3 + i] = uo[i][OW-1:0];
      f[6 + i] = lo[i][OW-1:0];
    end
    for (int i = 0; i < 9; i++) b.axes[i*OW +: OW] = f[i];
    b.equal = 1'b0;
    return b;
  endfunction

  task automatic add_pair(input logic [CW-1:0] sx, sy, sz, tx, ty, tz);
    pair_queue.insert(pair_queue.size(), {tz, ty, tx, sz, sy, sx});
  endtask

  function automatic logic [CW-1:0] rand_coord();
    return $urandom;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_look_at_basis_unit: errors");
      $finish;
    end
  end

  // Input side: record accepted words and predict their results.
  always @(posedge clk_i) begin
    in_fire <= s_tvalid && s_tready;
    if (s_tvalid && s_tready) begin
      basis_queue.insert(basis_queue.size(), look_at_basis(s_tdata));
      words_in <= words_in + 1;
    end
  end

  // Output side: compare every accepted word with the oldest prediction.
  always @(posedge clk_i) begin
    basis_t exp_b;
    if (m_tvalid && m_tready) begin
      if (basis_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h user %b", m_tdata, m_tuser);
      end else begin
        exp_b = basis_queue.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (m_tdata[i*OW +: OW] !== exp_b.axes[i*OW +: OW]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("axis field %0d: expected %h, got %h", i,
                       exp_b.axes[i*OW +: OW], m_tdata[i*OW +: OW]);
          end
        end
        if (m_tuser !== exp_b.equal) begin
          mismatches++;
          if (mismatches <= 10)
            $display("points_equal: expected %b, got %b", exp_b.equal, m_tuser);
        end
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;
  always @(negedge clk_i) begin
    logic            nxt_valid;
    logic [IN_W-1:0] nxt_data;
    nxt_valid = s_tvalid;
    nxt_data  = s_tdata;
    if (rst_ni) begin
      if (in_fire) void'(pair_queue.pop_front());
      if (!s_tvalid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          nxt_valid = 1'b0;
        end else if (pair_queue.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_data  = pair_queue[0];
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(40, 1);
            gap_left   = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(12, 1);
          end
        end else begin
          nxt_valid = 1'b0;
        end
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata  <= nxt_data;
  end

  // Receiver: a changing stall pattern, plus one long hold-off to back up the pipeline.
  int  rx_mode;
  int  rx_mode_left;
  int  hold_left;
  bit  hold_done;
  always @(negedge clk_i) begin
    logic nxt_ready;
    if (!hold_done && words_in >= 300) begin
      hold_done = 1'b1;
      hold_left = 600;
    end
    if (rx_mode_left <= 0) begin
      rx_mode      = $urandom_range(2, 0);
      rx_mode_left = $urandom_range(200, 10);
    end
    rx_mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else begin
      case (rx_mode)
        0: nxt_ready = 1'b1;
        1: nxt_ready = $urandom_range(1, 0);
        default: nxt_ready = ($urandom_range(3, 0) == 0);
      endcase
    end
    m_tready <= nxt_ready;
  end

  initial begin
    logic [CW-1:0] a, b, c;
    int kind;
    rst_ni     = 1'b0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    in_fire    = 1'b0;
    mismatches = 0;
    words_in   = 0;
    cycles     = 0;
    burst_left = 1;
    gap_left   = 0;
    rx_mode_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;

    // Coinciding points, vertical looks, axis directions and the coordinate extremes.
    add_pair(0, 0, 0, 0, 0, 0);
    add_pair(32'h7fffffff, 32'h80000000, 32'h12345678, 32'h7fffffff, 32'h80000000, 32'h12345678);
    add_pair(0, 0, 0, 0, 32'h00010000, 0);
    add_pair(0, 32'h7fffffff, 0, 0, 32'h80000000, 0);
    add_pair(5, 3, 7, 5, 32'hffffffff, 7);
    add_pair(0, 0, 0, 32'h00010000, 0, 0);
    add_pair(0, 0, 0, 32'hffff0000, 0, 0);
    add_pair(0, 0, 0, 0, 0, 32'h00010000);
    add_pair(0, 0, 0, 0, 0, 32'hffff0000);
    add_pair(0, 0, 0, 1, 0, 0);
    add_pair(0, 0, 0, 1, 1, 1);
    add_pair(32'h80000000, 32'h80000000, 32'h80000000,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h80000000, 32'h80000000, 32'h80000000);
    add_pair(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 0, 32'h80000000);
    add_pair(0, 0, 0, 32'h00030000, 32'h00040000, 0);
    add_pair(0, 0, 0, 1, 32'h7fffffff, 1);
    add_pair(0, 0, 0, 32'hffffffff, 32'h00000001, 32'hffffffff);
    add_pair(32'h10000, 32'h20000, 32'h30000, 32'h10001, 32'h20000, 32'h30000);

    for (int n = 0; n < N_RANDOM; n++) begin
      a = rand_coord();
      b = rand_coord();
      c = rand_coord();
      kind = $urandom_range(9, 0);
      case (kind)
        0: add_pair(a, b, c, a, b, c);
        1: add_pair(a, b, c, a, rand_coord(), c);
        2: add_pair(a, b, c, a + $urandom_range(15, 0) - 8, b + $urandom_range(15, 0) - 8,
                    c + $urandom_range(15, 0) - 8);
        3: add_pair(a, b, c, rand_coord(), b, c);
        4: add_pair(a, b, c, a, b, rand_coord());
        5: add_pair(a, b, c, a + ($urandom >> $urandom_range(31, 8)), b,
                    c - ($urandom >> $urandom_range(31, 8)));
        default: add_pair(a, b, c, rand_coord(), rand_coord(), rand_coord());
      endcase
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pair_queue.size() != 0 || s_tvalid || basis_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 50) @(posedge clk_i);
    if (mismatches == 0 && basis_queue.size() == 0) begin
      $display("tb_look_at_basis_unit: clean");
    end else begin
      $display("tb_look_at_basis_unit: errors");
    end
    $finish;
  end

endmodule
